### rtl/bda_pkg.sv
// Shared constants and types for the button debounce / auto-repeat unit.
// No dependencies; imported by button_debounce_autorepeat_unit and tb_top.
`timescale 1ns / 1ps
`default_nettype none

package bda_pkg;

	// Integrating debouncer range and repeat period
	localparam int unsigned INTEG_W      = 3;
	localparam int unsigned HOLD_W       = 16;
	localparam int unsigned REP_W        = 4;
	localparam logic [INTEG_W-1:0] INTEG_TOP     = INTEG_W'(5);
	localparam logic [REP_W-1:0]   REPEAT_PERIOD = REP_W'(10);

	// Configuration port layout
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam logic [0:0]  REG_HOLD_DELAY = 1'b0;   // register index, paddr[2]

	// Result of one sample tick
	typedef struct packed {
		logic level;
		logic press_pulse;
		logic release_pulse;
		logic repeat_pulse;
	} bda_result_t;

endpackage

`default_nettype wire

### rtl/button_debounce_autorepeat_unit.sv
// Button debouncer with auto-repeat: integrator, edge pulses, repeat timers,
// APB register for the hold delay, output register with skid stage.
// Depends on bda_pkg.
//
//   channel   handshake                  payload
//   -------   -------------------------  ------------------------------------
//   input     in_valid / in_stall        raw_sample
//   output    out_valid / out_stall      level, press_pulse, release_pulse,
//                                        repeat_pulse
//   config    APB psel/penable/pwrite    paddr, pwdata, prdata (pready = 1)
//
// One sample per clock while in_stall is low; the result goes to the output
// register, or to a one-entry skid stage while out_stall is high. The state
// update is a single pass of small logic at the input transaction. in_stall
// rises only while that stage is full, so throughput is one per cycle unstalled.
// Reset (arst_n low, asynchronous) clears the debouncer and timer state, hold_delay and valids.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_autorepeat_unit (
	input  wire                        clk,
	input  wire                        arst_n,
	// sample input
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire                        raw_sample,
	// result output
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic                       level,
	output logic                       press_pulse,
	output logic                       release_pulse,
	output logic                       repeat_pulse,
	// configuration
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire  [bda_pkg::ADDR_W-1:0] paddr,
	input  wire  [bda_pkg::DATA_W-1:0] pwdata,
	output logic [bda_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import bda_pkg::*;

	logic [HOLD_W-1:0]  hold_delay_q;
	logic [INTEG_W-1:0] integ_q, integ_d;
	logic               deb_q, deb_d;
	logic               rpt_on_q, rpt_on_d;
	logic [HOLD_W-1:0]  hold_cnt_q, hold_cnt_d;
	logic [REP_W-1:0]   rep_cnt_q, rep_cnt_d;
	logic [INTEG_W-1:0] integ_clip;
	bda_result_t        res_d, out_q, skid_q;
	logic               out_valid_q, skid_valid_q;
	logic               in_fire, out_free;

	// APB register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HOLD_DELAY) ?
		{{(DATA_W-HOLD_W){1'b0}}, hold_delay_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_delay_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == REG_HOLD_DELAY) begin
			hold_delay_q <= pwdata[HOLD_W-1:0];
		end
	end

	// Per-tick state update
	always_comb begin
		integ_clip = (integ_q > INTEG_TOP) ? INTEG_TOP : integ_q;
		integ_d    = integ_q;
		deb_d      = deb_q;
		if (raw_sample) begin
			if (integ_q < INTEG_TOP) integ_d = integ_q + INTEG_W'(1);
			if (integ_d >= INTEG_TOP) deb_d = 1'b1;
		end else begin
			integ_d = (integ_clip != '0) ? integ_clip - INTEG_W'(1) : integ_clip;
			if (integ_d == '0) deb_d = 1'b0;
		end

		res_d.level         = deb_d;
		res_d.press_pulse   = !deb_q && deb_d;
		res_d.release_pulse = deb_q && !deb_d;
		res_d.repeat_pulse  = 1'b0;

		// press restarts the hold and repeat timers; the press tick counts as held
		rpt_on_d   = res_d.press_pulse ? 1'b0 : rpt_on_q;
		hold_cnt_d = res_d.press_pulse ? '0 : hold_cnt_q;
		rep_cnt_d  = res_d.press_pulse ? '0 : rep_cnt_q;

		if (hold_delay_q != '0 && deb_d) begin
			if (rpt_on_d) begin
				rep_cnt_d = rep_cnt_d + REP_W'(1);
				if (rep_cnt_d == REPEAT_PERIOD) begin
					res_d.repeat_pulse = 1'b1;
					rep_cnt_d          = '0;
				end
			end else begin
				hold_cnt_d = hold_cnt_d + HOLD_W'(1);
				if (hold_cnt_d == hold_delay_q) begin
					rpt_on_d   = 1'b1;
					hold_cnt_d = '0;
				end
			end
		end
	end

	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !skid_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			deb_q      <= 1'b0;
			rpt_on_q   <= 1'b0;
			hold_cnt_q <= '0;
			rep_cnt_q  <= '0;
		end else if (in_fire) begin
			integ_q    <= integ_d;
			deb_q      <= deb_d;
			rpt_on_q   <= rpt_on_d;
			hold_cnt_q <= hold_cnt_d;
			rep_cnt_q  <= rep_cnt_d;
		end
	end

	// Output register and skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (in_fire) out_q <= res_d;
		end else if (in_fire) begin
			skid_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign level         = out_q.level;
	assign press_pulse   = out_q.press_pulse;
	assign release_pulse = out_q.release_pulse;
	assign repeat_pulse  = out_q.repeat_pulse;

endmodule

`default_nettype wire

### sim/tb_top.sv
// Testbench for button_debounce_autorepeat_unit: drives raw samples and hold_delay
// writes, checks each result transaction against a cycle-free model of the debouncer.
// Depends on bda_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_top;
	import bda_pkg::*;

	localparam int CLK_HALF         = 5;
	localparam int CYCLE_LIMIT      = 1_500_000;
	localparam int PHASE_ITEMS      = 160;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES    = 6;
	localparam int MAX_PRINTED      = 40;
	localparam logic [ADDR_W-1:0] HOLD_DELAY_ADDR = {REG_HOLD_DELAY, 2'b00};
	localparam logic [ADDR_W-1:0] UNMAPPED_ADDR   = {~REG_HOLD_DELAY, 2'b00};

	// Expected-result tracking: debouncer state, hold_delay copy, result queue
	class debounce_scoreboard;
		logic [HOLD_W-1:0]  hold_delay;
		logic [INTEG_W-1:0] integ;
		logic               deb;
		logic               repeating;
		logic [HOLD_W-1:0]  hold_cnt;
		logic [REP_W-1:0]   rep_cnt;
		bda_result_t        pending_results[$];
		int                 n_fail;

		function new();
			hold_delay = '0;
			integ      = '0;
			deb        = 1'b0;
			repeating  = 1'b0;
			hold_cnt   = '0;
			rep_cnt    = '0;
			n_fail     = 0;
		endfunction

		task report(string msg);
			if (n_fail < MAX_PRINTED)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			n_fail++;
		endtask

		// One sample tick: integrator, edge detect, hold / repeat timers
		function bda_result_t debounce_tick(logic s);
			logic        was;
			bda_result_t r;
			was = deb;
			r   = '0;
			if (s) begin
				if (integ < INTEG_TOP)
					integ = integ + 1'b1;
				if (integ >= INTEG_TOP)
					deb = 1'b1;
			end else begin
				if (integ > INTEG_TOP)
					integ = INTEG_TOP;
				if (integ != 0)
					integ = integ - 1'b1;
				if (integ == 0)
					deb = 1'b0;
			end
			r.press_pulse   = !was && deb;
			r.release_pulse = was && !deb;
			// press restarts the timers; the press tick is the first held tick
			if (r.press_pulse) begin
				hold_cnt  = '0;
				rep_cnt   = '0;
				repeating = 1'b0;
			end
			if (hold_delay != 0 && deb) begin
				if (repeating) begin
					rep_cnt = rep_cnt + 1'b1;
					if (rep_cnt == REPEAT_PERIOD) begin
						r.repeat_pulse = 1'b1;
						rep_cnt        = '0;
					end
				end else begin
					hold_cnt = hold_cnt + 1'b1;
					if (hold_cnt == hold_delay) begin
						repeating = 1'b1;
						hold_cnt  = '0;
					end
				end
			end
			r.level = deb;
			return r;
		endfunction

		function void note_sample(logic s);
			pending_results.push_back(debounce_tick(s));
		endfunction

		task check_result(bda_result_t got);
			bda_result_t want;
			string       names[4];
			names = '{"repeat_pulse", "release_pulse", "press_pulse", "level"};
			if (pending_results.size() == 0) begin
				report($sformatf("result %b with nothing expected", got));
				return;
			end
			want = pending_results.pop_front();
			for (int i = 3; i >= 0; i--)
				if (got[i] !== want[i])
					report($sformatf("%s got %b want %b", names[i], got[i], want[i]));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                raw_sample;
	logic                out_valid;
	logic                out_stall;
	logic                level;
	logic                press_pulse;
	logic                release_pulse;
	logic                repeat_pulse;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	debounce_scoreboard  sb;
	int                  cycles;
	int                  items_in_phase;
	bit                  calm;
	bit                  gappy;
	bit                  long_hold_req;

	button_debounce_autorepeat_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.raw_sample    (raw_sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.level         (level),
		.press_pulse   (press_pulse),
		.release_pulse (release_pulse),
		.repeat_pulse  (repeat_pulse),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({level, press_pulse, release_pulse, repeat_pulse});
	end

	// Receiver stall: random bursts, one long hold-off on request, none when calm
	initial begin : rx_stall
		int   run;
		logic val;
		out_stall = 1'b0;
		run       = 0;
		val       = 1'b0;
		forever begin
			@(negedge clk);
			if (run == 0) begin
				if (long_hold_req) begin
					val           = 1'b1;
					run           = LONG_HOLD_CYCLES;
					long_hold_req = 1'b0;
				end else if (calm) begin
					val = 1'b0;
					run = 1;
				end else if ($urandom_range(0, 2) == 0) begin
					val = 1'b1;
					run = $urandom_range(1, 14);
				end else begin
					val = 1'b0;
					run = $urandom_range(1, 40);
				end
			end
			out_stall <= val;
			run--;
		end
	end

	task idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			in_valid   <= 1'b0;
			raw_sample <= $urandom_range(0, 1);
		end
	endtask

	// One sample transaction, with an optional random gap ahead of it
	task send_sample(logic s);
		if (!calm && gappy && $urandom_range(0, 7) == 0)
			idle_cycles($urandom_range(1, 14));
		@(negedge clk);
		in_valid   <= 1'b1;
		raw_sample <= s;
		do @(posedge clk); while (in_stall);
		sb.note_sample(s);
		items_in_phase++;
	endtask

	// Stop offering and wait until every expected result is back
	task drain();
		idle_cycles(1);
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task cfg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task cfg_readback(logic [HOLD_W-1:0] want);
		logic [DATA_W-1:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= HOLD_DELAY_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== DATA_W'(want))
			sb.report($sformatf("hold_delay read %h want %h", got, want));
	endtask

	// Upper data bits are junk; only the low 16 land in the register
	task set_hold_delay(logic [HOLD_W-1:0] d);
		logic [DATA_W-1:0] junk;
		junk = $urandom;
		cfg_write(HOLD_DELAY_ADDR, {junk[DATA_W-1:HOLD_W], d});
		sb.hold_delay = d;
		cfg_readback(d);
	endtask

	// Mostly press / hold / release with bounce, sometimes plain noise
	task play_burst();
		int kind;
		kind  = $urandom_range(0, 3);
		gappy = ($urandom_range(0, 2) != 0);
		if (kind != 0) begin
			repeat ($urandom_range(0, 4)) send_sample($urandom_range(0, 1));
			repeat ($urandom_range(5, 70)) send_sample($urandom_range(0, 15) != 0);
			repeat ($urandom_range(0, 4)) send_sample($urandom_range(0, 1));
			repeat ($urandom_range(5, 15)) send_sample(1'b0);
		end else begin
			repeat ($urandom_range(1, 12)) send_sample($urandom_range(0, 1));
		end
	endtask

	initial begin : main
		logic [22:0]       press_seq;
		logic [HOLD_W-1:0] delays[8];
		sb            = new();
		cycles        = 0;
		items_in_phase = 0;
		calm          = 1'b0;
		gappy         = 1'b0;
		long_hold_req = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		raw_sample    = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: press, hold into one repeat, bounce while held, release.
		// An unmapped write must leave hold_delay alone.
		set_hold_delay(16'd2);
		cfg_write(UNMAPPED_ADDR, $urandom);
		cfg_readback(16'd2);
		press_seq = 23'b1111111111111111_01_00000;
		for (int i = 22; i >= 0; i--)
			send_sample(press_seq[i]);
		drain();

		// Delay lowered below hold_count: counter runs past it without repeating
		set_hold_delay(16'd40);
		repeat (30) send_sample(1'b1);
		drain();
		set_hold_delay(16'd20);
		repeat (60) send_sample(1'b1);
		repeat (8) send_sample(1'b0);
		drain();

		// Random phases over several delays, extremes included
		delays = '{16'd0, 16'd1, 16'd2, 16'd9, 16'd10, 16'd25, 16'hFFFF, 16'd3};
		for (int p = 0; p < 8; p++) begin
			set_hold_delay(delays[p]);
			if (p == 2)
				long_hold_req = 1'b1;
			if (p == 7)
				calm = 1'b1;
			items_in_phase = 0;
			while (items_in_phase < PHASE_ITEMS)
				play_burst();
			drain();
		end

		if (sb.n_fail == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
